// ----- sv/tea_pkg.sv -----
// types, constants and helpers shared by the triangle edge adjacency block
package tea_pkg;

	localparam int MAX_TRI = 64;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;
	localparam int LINK_W  = 7;

	localparam logic signed [LINK_W-1:0] LINK_NONE = -7'sd1;

	localparam logic [1:0] SIDE_AB = 2'd0;
	localparam logic [1:0] SIDE_BC = 2'd1;
	localparam logic [1:0] SIDE_CA = 2'd2;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} point_t;

	typedef struct packed {
		point_t a;
		point_t b;
		point_t c;
	} tri_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} link_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		link_t            data;
	} lk_wr_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CUR_RD,
		ST_CUR_LD,
		ST_SCAN,
		ST_CUR_WB,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

	function automatic logic signed [LINK_W-1:0] to_link(input link_t l);
		return l.vld ? $signed({1'b0, l.idx}) : LINK_NONE;
	endfunction

endpackage

// ----- sv/triangle_edge_adjacency_top.sv -----
// top level: triangle load, lane-parallel edge linking and result output
// Triangles are taken one per cycle into the vertex memory until one marked last arrives
// (at most 64 are kept; later ones are dropped, but their last flag still counts). Linking
// then walks every stored triangle against every other one, reading one other triangle per
// cycle from the single read port of the vertex memory while three side lanes test AB, BC
// and CA at once. Results then leave in load order, each one only after the one before it
// has been taken by the receiver. No new triangle is taken until the whole set is reported.
module triangle_edge_adjacency_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tri_valid,
	output logic                              tri_stall,
	input  logic [31:0]                       a_x,
	input  logic [31:0]                       a_y,
	input  logic [31:0]                       a_z,
	input  logic [31:0]                       b_x,
	input  logic [31:0]                       b_y,
	input  logic [31:0]                       b_z,
	input  logic [31:0]                       c_x,
	input  logic [31:0]                       c_y,
	input  logic [31:0]                       c_z,
	input  logic                              last_triangle,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [tea_pkg::IDX_W-1:0]         cell_index,
	output logic signed [tea_pkg::LINK_W-1:0] link_ab,
	output logic signed [tea_pkg::LINK_W-1:0] link_bc,
	output logic signed [tea_pkg::LINK_W-1:0] link_ca,
	output logic                              last_cell
);
	import tea_pkg::*;

	state_t state_q, state_nx;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cur_q;
	logic [CNT_W-1:0] oth_q;
	logic             ev_vld_s1;
	logic [IDX_W-1:0] ev_oth_s1;

	tri_t   cur_tri_q;
	link_t  cur_link_q [3];
	point_t cur_pt [3];

	logic             tri_acc;
	logic             res_acc;
	logic             store_full;
	logic             set_done;
	logic             oth_left;

	tri_t             in_tri;
	logic             vs_we;
	logic [IDX_W-1:0] vs_raddr;
	tri_t             vs_rdata;

	lk_wr_t lk_wr [3];
	link_t  lk_rdata [3];
	logic   lk_clear;

	logic       lane_match [3];
	logic [1:0] lane_side [3];
	logic       skip;
	logic       full;
	logic       do_eval;
	logic [2:0] hit;

	assign in_tri     = '{a: '{x: a_x, y: a_y, z: a_z},
	                      b: '{x: b_x, y: b_y, z: b_z},
	                      c: '{x: c_x, y: c_y, z: c_z}};
	assign tri_acc    = tri_valid && !tri_stall;
	assign res_acc    = res_valid && !res_stall;
	assign store_full = (count_q == CNT_W'(MAX_TRI));
	assign set_done   = (cur_q + CNT_W'(1) == count_q);
	assign oth_left   = (oth_q < count_q);

	tea_vstore u_vstore (
		.clk   (clk),
		.we    (vs_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (in_tri),
		.raddr (vs_raddr),
		.rdata (vs_rdata)
	);

	tea_lstore u_lstore (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (lk_clear),
		.wr     (lk_wr),
		.raddr  (cur_q[IDX_W-1:0]),
		.rdata  (lk_rdata)
	);

	// edges of the current triangle: AB, BC, CA
	assign cur_pt[0] = cur_tri_q.a;
	assign cur_pt[1] = cur_tri_q.b;
	assign cur_pt[2] = cur_tri_q.c;

	for (genvar s = 0; s < 3; s++) begin : g_lane
		tea_lane u_lane (
			.oth   (vs_rdata),
			.l     (cur_pt[s]),
			.r     (cur_pt[(s + 1) % 3]),
			.match (lane_match[s]),
			.side  (lane_side[s])
		);
	end

	// merge stage: decide per pair, then per side
	always_comb begin
		skip = (ev_oth_s1 == cur_q[IDX_W-1:0]);
		full = 1'b1;
		for (int s = 0; s < 3; s++) begin
			if (cur_link_q[s].vld && cur_link_q[s].idx == ev_oth_s1) begin
				skip = 1'b1;
			end
			full = full && cur_link_q[s].vld;
		end
		do_eval = (state_q == ST_SCAN) && ev_vld_s1 && !skip && !full;
		for (int s = 0; s < 3; s++) begin
			hit[s] = do_eval && !cur_link_q[s].vld && lane_match[s];
		end
	end

	// back links to the other triangle, later lane wins a side; write-back: own links
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lk_wr[j] = '0;
			if (state_q == ST_CUR_WB) begin
				lk_wr[j].we   = 1'b1;
				lk_wr[j].addr = cur_q[IDX_W-1:0];
				lk_wr[j].data = cur_link_q[j];
			end else begin
				for (int s = 0; s < 3; s++) begin
					if (hit[s] && lane_side[s] == 2'(j)) begin
						lk_wr[j].we   = 1'b1;
						lk_wr[j].addr = ev_oth_s1;
						lk_wr[j].data = '{vld: 1'b1, idx: cur_q[IDX_W-1:0]};
					end
				end
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (tri_acc && last_triangle) begin
					state_nx = ST_CUR_RD;
				end
			end
			ST_CUR_RD:   state_nx = ST_CUR_LD;
			ST_CUR_LD:   state_nx = ST_SCAN;
			ST_SCAN: begin
				if (!oth_left && !ev_vld_s1) begin
					state_nx = ST_CUR_WB;
				end
			end
			ST_CUR_WB:   state_nx = set_done ? ST_OUT_RD : ST_CUR_RD;
			ST_OUT_RD:   state_nx = ST_OUT_LD;
			ST_OUT_LD:   state_nx = ST_OUT_WAIT;
			ST_OUT_WAIT: begin
				if (res_acc) begin
					state_nx = set_done ? ST_LOAD : ST_OUT_RD;
				end
			end
			default:     state_nx = ST_LOAD;
		endcase
	end

	always_comb begin
		tri_stall = (state_q != ST_LOAD);
		vs_we     = (state_q == ST_LOAD) && tri_acc && !store_full;
		vs_raddr  = (state_q == ST_SCAN) ? oth_q[IDX_W-1:0] : cur_q[IDX_W-1:0];
		lk_clear  = (state_q == ST_OUT_WAIT) && res_acc && set_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			cur_q     <= '0;
			oth_q     <= '0;
			ev_vld_s1 <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				ST_LOAD: begin
					if (vs_we) begin
						count_q <= count_q + CNT_W'(1);
					end
					cur_q <= '0;
				end
				ST_CUR_LD: begin
					oth_q     <= '0;
					ev_vld_s1 <= 1'b0;
				end
				ST_SCAN: begin
					ev_vld_s1 <= oth_left;
					if (oth_left) begin
						oth_q <= oth_q + CNT_W'(1);
					end
				end
				ST_CUR_WB: begin
					cur_q <= set_done ? '0 : cur_q + CNT_W'(1);
				end
				ST_OUT_LD: begin
					res_valid <= 1'b1;
				end
				ST_OUT_WAIT: begin
					if (res_acc) begin
						res_valid <= 1'b0;
						if (set_done) begin
							count_q <= '0;
						end else begin
							cur_q <= cur_q + CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			ev_oth_s1 <= oth_q[IDX_W-1:0];
		end
		if (state_q == ST_CUR_LD) begin
			cur_tri_q <= vs_rdata;
			for (int s = 0; s < 3; s++) begin
				cur_link_q[s] <= lk_rdata[s];
			end
		end else begin
			for (int s = 0; s < 3; s++) begin
				if (hit[s]) begin
					cur_link_q[s] <= '{vld: 1'b1, idx: ev_oth_s1};
				end
			end
		end
		if (state_q == ST_OUT_LD) begin
			cell_index <= cur_q[IDX_W-1:0];
			link_ab    <= to_link(lk_rdata[0]);
			link_bc    <= to_link(lk_rdata[1]);
			link_ca    <= to_link(lk_rdata[2]);
			last_cell  <= set_done;
		end
	end

`ifndef NO_ASSERTIONS
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> state_q == ST_OUT_WAIT)
		else $error("result shown outside the output wait state");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TRI))
		else $error("triangle count beyond store depth");

	a_eval_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && ev_vld_s1) |-> CNT_W'(ev_oth_s1) < count_q)
		else $error("scan evaluates a triangle that was never loaded");

	a_no_self_link: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_CUR_WB) |->
		!((cur_link_q[0].vld && cur_link_q[0].idx == cur_q[IDX_W-1:0]) ||
		  (cur_link_q[1].vld && cur_link_q[1].idx == cur_q[IDX_W-1:0]) ||
		  (cur_link_q[2].vld && cur_link_q[2].idx == cur_q[IDX_W-1:0])))
		else $error("triangle linked to itself");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(tri_acc && last_triangle) |-> tri_stall)
		else $error("input taken while linking");
`endif

endmodule

// ----- sv/tea_lane.sv -----
// one side lane: finds the side of the other triangle that matches a given edge
module tea_lane (
	input  tea_pkg::tri_t   oth,
	input  tea_pkg::point_t l,
	input  tea_pkg::point_t r,
	output logic            match,
	output logic [1:0]      side
);
	import tea_pkg::*;

	logic la, lb, lc, ra, rb, rc;

	assign la = (oth.a == l);
	assign lb = (oth.b == l);
	assign lc = (oth.c == l);
	assign ra = (oth.a == r);
	assign rb = (oth.b == r);
	assign rc = (oth.c == r);

	// priority follows the endpoint order a, b, c of the other triangle
	always_comb begin
		match = 1'b1;
		side  = SIDE_AB;
		if (la && rb) begin
			side = SIDE_AB;
		end else if (la && rc) begin
			side = SIDE_CA;
		end else if (lb && ra) begin
			side = SIDE_AB;
		end else if (lb && rc) begin
			side = SIDE_BC;
		end else if (lc && ra) begin
			side = SIDE_CA;
		end else if (lc && rb) begin
			side = SIDE_BC;
		end else begin
			match = 1'b0;
		end
	end

endmodule

// ----- sv/tea_vstore.sv -----
// vertex memory, one triangle per word, registered read
module tea_vstore (
	input  logic                      clk,
	input  logic                      we,
	input  logic [tea_pkg::IDX_W-1:0] waddr,
	input  tea_pkg::tri_t             wdata,
	input  logic [tea_pkg::IDX_W-1:0] raddr,
	output tea_pkg::tri_t             rdata
);
	import tea_pkg::*;

	tri_t mem_q [MAX_TRI];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/tea_lstore.sv -----
// link table: one memory per side with per-entry valid bits, registered read
module tea_lstore (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  tea_pkg::lk_wr_t           wr [3],
	input  logic [tea_pkg::IDX_W-1:0] raddr,
	output tea_pkg::link_t            rdata [3]
);
	import tea_pkg::*;

	for (genvar s = 0; s < 3; s++) begin : g_side
		logic [IDX_W-1:0]   mem_q [MAX_TRI];
		logic [MAX_TRI-1:0] vld_q;
		logic [IDX_W-1:0]   rd_idx_q;
		logic               rd_vld_q;

		always_ff @(posedge clk) begin
			if (wr[s].we) begin
				mem_q[wr[s].addr] <= wr[s].data.idx;
			end
			rd_idx_q <= mem_q[raddr];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q    <= '0;
				rd_vld_q <= 1'b0;
			end else begin
				if (clear) begin
					vld_q <= '0;
				end else if (wr[s].we) begin
					vld_q[wr[s].addr] <= wr[s].data.vld;
				end
				rd_vld_q <= vld_q[raddr];
			end
		end

		assign rdata[s] = '{vld: rd_vld_q, idx: rd_idx_q};
	end

endmodule
